/* rtl/core/assert_macros.svh */
// assertion macros shared by the core modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/core/mrse_pkg.sv */
// types, constants and lookup functions of the mixed radix segment encoder
`timescale 1ns / 1ps

package mrse_pkg;

  localparam logic [1:0] MODE_CLOCK = 2'd0;
  localparam logic [1:0] MODE_TEMP  = 2'd1;
  localparam logic [1:0] MODE_MENU  = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam logic [1:0] POS_FIRST = 2'd3;
  localparam logic [1:0] POS_LAST  = 2'd0;
  localparam logic [1:0] POS_NONE  = 2'd0;

  localparam logic [5:0] RADIX_6  = 6'd6;
  localparam logic [5:0] RADIX_10 = 6'd10;
  localparam logic [5:0] RADIX_16 = 6'd16;
  localparam logic [5:0] RADIX_32 = 6'd32;

  // reciprocal constants, exact for any 16-bit dividend
  localparam logic [15:0] RECIP_6        = 16'd43691;
  localparam int          RECIP_6_SHIFT  = 18;
  localparam logic [15:0] RECIP_10       = 16'd52429;
  localparam int          RECIP_10_SHIFT = 19;

  localparam logic [4:0] BLANK_GLYPH  = 5'd10;
  localparam logic [4:0] NUM_GLYPHS   = 5'd26;
  localparam logic [5:0] ON_TIME_BASE = 6'h20;

  typedef struct packed {
    logic       valid;
    logic [1:0] pos;
    logic [4:0] digit;
    logic [1:0] mode;
  } dig_t;

  function automatic logic [5:0] radix_of(input logic [1:0] mode, input logic [1:0] pos);
    logic [5:0] r;
    r = RADIX_32;
    case (mode)
      MODE_CLOCK: begin
        case (pos)
          2'd0:    r = RADIX_16;
          2'd1:    r = RADIX_10;
          2'd2:    r = RADIX_6;
          default: r = RADIX_10;
        endcase
      end
      MODE_TEMP: begin
        case (pos)
          2'd0:    r = RADIX_16;
          2'd1:    r = RADIX_10;
          2'd2:    r = RADIX_10;
          default: r = RADIX_16;
        endcase
      end
      default: r = RADIX_32;
    endcase
    return r;
  endfunction

  // weight of each position: product of the radices below it, mod 2^16
  function automatic logic [15:0] cue_of(input logic [1:0] mode, input logic [1:0] pos);
    logic [15:0] c;
    c = 16'd1;
    case (mode)
      MODE_CLOCK: begin
        case (pos)
          2'd0:    c = 16'd600;
          2'd1:    c = 16'd60;
          2'd2:    c = 16'd10;
          default: c = 16'd1;
        endcase
      end
      MODE_TEMP: begin
        case (pos)
          2'd0:    c = 16'd1600;
          2'd1:    c = 16'd160;
          2'd2:    c = 16'd16;
          default: c = 16'd1;
        endcase
      end
      default: begin
        case (pos)
          2'd0:    c = 16'd32768;
          2'd1:    c = 16'd1024;
          2'd2:    c = 16'd32;
          default: c = 16'd1;
        endcase
      end
    endcase
    return c;
  endfunction

  // segments: bit6=a bit5=b bit4=c bit3=d bit2=e bit1=f bit0=g
  function automatic logic [6:0] glyph_segs(input logic [4:0] idx);
    logic [6:0] s;
    case (idx)
      5'd0:    s = 7'h7e;
      5'd1:    s = 7'h30;
      5'd2:    s = 7'h6d;
      5'd3:    s = 7'h79;
      5'd4:    s = 7'h33;
      5'd5:    s = 7'h5b;
      5'd6:    s = 7'h5f;
      5'd7:    s = 7'h70;
      5'd8:    s = 7'h7f;
      5'd9:    s = 7'h7b;
      5'd10:   s = 7'h00;
      5'd11:   s = 7'h1d;
      5'd12:   s = 7'h01;
      5'd13:   s = 7'h1f;
      5'd14:   s = 7'h47;
      5'd15:   s = 7'h4e;
      5'd16:   s = 7'h0f;
      5'd17:   s = 7'h37;
      5'd18:   s = 7'h15;
      5'd19:   s = 7'h05;
      5'd20:   s = 7'h3c;
      5'd21:   s = 7'h3d;
      5'd22:   s = 7'h0e;
      5'd23:   s = 7'h10;
      5'd24:   s = 7'h4f;
      5'd25:   s = 7'h77;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] map_port1(input logic [6:0] s);
    return {s[6], s[1], 1'b0, s[3], s[2], 3'b000};
  endfunction

  function automatic logic [7:0] map_port2(input logic [6:0] s);
    return {4'b0000, s[5], 1'b0, s[0], s[4]};
  endfunction

  function automatic logic [2:0] seg_count(input logic [6:0] s);
    logic [2:0] n;
    n = 3'd0;
    for (int b = 0; b < 7; b++) begin
      n = n + 3'(s[b]);
    end
    return n;
  endfunction

endpackage

/* rtl/core/mrse_split.sv */
// input register and per-position digit extraction with advance
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mrse_split (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [15:0]        in_value,
  input  logic [1:0]         in_radix_mode,
  input  logic [1:0]         in_advance_position,
  output logic               busy,
  output mrse_pkg::dig_t     dig_o
);

  logic           s1_valid_r, s1_valid_nxt;
  logic [1:0]     s1_pos_r, s1_pos_nxt;
  logic [15:0]    s1_rem_r, s1_rem_nxt;
  logic [1:0]     s1_mode_r;
  logic [1:0]     s1_adv_r;
  mrse_pkg::dig_t dig_r, dig_nxt;

  logic           accept;
  logic [5:0]     rad;
  logic [15:0]    recip;
  logic [31:0]    prod;
  logic [15:0]    quo;
  logic [15:0]    back;
  logic [4:0]     rem_d;
  logic [5:0]     inc;
  logic [4:0]     digit;

  assign busy   = s1_valid_r && (s1_pos_r != mrse_pkg::POS_LAST);
  assign accept = start && !busy;

  always_comb begin
    rad   = mrse_pkg::radix_of(s1_mode_r, s1_pos_r);
    recip = (rad == mrse_pkg::RADIX_6) ? mrse_pkg::RECIP_6 : mrse_pkg::RECIP_10;
    prod  = 32'(s1_rem_r) * 32'(recip);
    case (rad)
      mrse_pkg::RADIX_6: begin
        quo  = 16'(prod >> mrse_pkg::RECIP_6_SHIFT);
        back = (quo << 2) + (quo << 1);
      end
      mrse_pkg::RADIX_10: begin
        quo  = 16'(prod >> mrse_pkg::RECIP_10_SHIFT);
        back = (quo << 3) + (quo << 1);
      end
      mrse_pkg::RADIX_16: begin
        quo  = s1_rem_r >> 4;
        back = quo << 4;
      end
      default: begin
        quo  = s1_rem_r >> 5;
        back = quo << 5;
      end
    endcase
    rem_d = 5'(s1_rem_r - back);
    inc   = {1'b0, rem_d} + 6'd1;
    digit = rem_d;
    if (s1_adv_r != mrse_pkg::POS_NONE && s1_adv_r == s1_pos_r) begin
      digit = (inc >= rad) ? 5'd0 : inc[4:0];
    end
  end

  always_comb begin
    s1_valid_nxt = accept || busy;
    s1_pos_nxt   = accept ? mrse_pkg::POS_FIRST : s1_pos_r - 2'd1;
    s1_rem_nxt   = accept ? in_value : quo;
    dig_nxt.valid = s1_valid_r;
    dig_nxt.pos   = s1_pos_r;
    dig_nxt.digit = digit;
    dig_nxt.mode  = s1_mode_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s1_pos_r    <= mrse_pkg::POS_LAST;
      dig_r.valid <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s1_pos_r   <= s1_pos_nxt;
      dig_r      <= dig_nxt;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    s1_rem_r <= s1_rem_nxt;
    if (accept) begin
      s1_mode_r <= in_radix_mode;
      s1_adv_r  <= in_advance_position;
    end
  end

  assign dig_o = dig_r;

  `ASSERT_NEXT(a_load_first, clk, rst_n, accept, s1_valid_r && s1_pos_r == mrse_pkg::POS_FIRST)
  `ASSERT_SAME(a_digit_range, clk, rst_n, dig_r.valid, 6'(dig_r.digit) < mrse_pkg::radix_of(dig_r.mode, dig_r.pos))

endmodule

/* rtl/core/mrse_glyph.sv */
// value recomposition, glyph lookup and result register
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mrse_glyph (
  input  logic           clk,
  input  logic           rst_n,
  input  mrse_pkg::dig_t dig_i,
  output logic           out_valid,
  output logic [1:0]     out_digit_position,
  output logic [7:0]     out_port1_bits,
  output logic [7:0]     out_port2_bits,
  output logic [5:0]     out_on_time,
  output logic [4:0]     out_glyph_index,
  output logic           out_bad_glyph,
  output logic [15:0]    out_packed_value,
  output logic           out_last
);

  logic        valid_r;
  logic [15:0] acc_r, acc_nxt;
  logic [1:0]  pos_r;
  logic [7:0]  port1_r, port1_nxt;
  logic [7:0]  port2_r, port2_nxt;
  logic [5:0]  on_time_r, on_time_nxt;
  logic [4:0]  glyph_r, glyph_nxt;
  logic        bad_r, bad_nxt;
  logic [15:0] packed_r, packed_nxt;
  logic        last_r, last_nxt;

  logic [20:0] term;
  logic [6:0]  segs;
  logic        is_last;

  always_comb begin
    is_last = (dig_i.pos == mrse_pkg::POS_LAST);
    term    = 21'(dig_i.digit) * 21'(mrse_pkg::cue_of(dig_i.mode, dig_i.pos));
    acc_nxt = ((dig_i.pos == mrse_pkg::POS_FIRST) ? 16'd0 : acc_r) + term[15:0];

    // zero in the top digit shows blank
    glyph_nxt = (is_last && dig_i.digit == 5'd0) ? mrse_pkg::BLANK_GLYPH : dig_i.digit;
    bad_nxt   = (glyph_nxt >= mrse_pkg::NUM_GLYPHS);
    segs      = bad_nxt ? 7'd0 : mrse_pkg::glyph_segs(glyph_nxt);

    port1_nxt   = mrse_pkg::map_port1(segs);
    port2_nxt   = mrse_pkg::map_port2(segs);
    on_time_nxt = mrse_pkg::ON_TIME_BASE | 6'(mrse_pkg::seg_count(segs));
    packed_nxt  = is_last ? acc_nxt : 16'd0;
    last_nxt    = is_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= dig_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dig_i.valid) begin
      acc_r <= acc_nxt;
    end
    pos_r     <= dig_i.pos;
    port1_r   <= port1_nxt;
    port2_r   <= port2_nxt;
    on_time_r <= on_time_nxt;
    glyph_r   <= glyph_nxt;
    bad_r     <= bad_nxt;
    packed_r  <= packed_nxt;
    last_r    <= last_nxt;
  end

  assign out_valid          = valid_r;
  assign out_digit_position = pos_r;
  assign out_port1_bits     = port1_r;
  assign out_port2_bits     = port2_r;
  assign out_on_time        = on_time_r;
  assign out_glyph_index    = glyph_r;
  assign out_bad_glyph      = bad_r;
  assign out_packed_value   = packed_r;
  assign out_last           = last_r;

  `ASSERT_NEXT(a_last_follows, clk, rst_n, dig_i.valid && dig_i.pos == mrse_pkg::POS_LAST, out_valid && out_last)
  `ASSERT_SAME(a_packed_zero, clk, rst_n, out_valid && !out_last, out_packed_value == 16'd0)
  `ASSERT_SAME(a_bad_blank, clk, rst_n, out_valid && out_bad_glyph, out_port1_bits == 8'd0 && out_port2_bits == 8'd0 && out_on_time == mrse_pkg::ON_TIME_BASE)

endmodule

/* rtl/core/mixed_radix_seven_segment_encoder_core.sv */
// top level of the mixed radix seven segment encoder
`timescale 1ns / 1ps

// Usage:
// A request (in_value, in_radix_mode, in_advance_position) is taken at a rising
// edge where start is high and busy is low. Each request yields four results on
// the out_ ports, one per cycle, marked by out_valid, for digit positions 3, 2,
// 1, 0 in that order; out_last marks position 0, which also carries the
// recomposed value on out_packed_value.
// A request is registered in mrse_split, each digit in its digit register and
// each result in the mrse_glyph output registers. The single digit extractor
// takes one position per cycle (multiply for radix 6 and 10, shift for 16, 32);
// busy is high for positions 3, 2 and 1, so a new request can be taken in the
// cycle that extracts the last digit of the previous one.
// Reset (rst_n low, synchronous) drops any request in flight and clears
// out_valid and busy.
// The receiver cannot stall: each result is on the ports for exactly one cycle.

module mixed_radix_seven_segment_encoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_value,
  input  logic [1:0]  in_radix_mode,
  input  logic [1:0]  in_advance_position,
  output logic        out_valid,
  output logic [1:0]  out_digit_position,
  output logic [7:0]  out_port1_bits,
  output logic [7:0]  out_port2_bits,
  output logic [5:0]  out_on_time,
  output logic [4:0]  out_glyph_index,
  output logic        out_bad_glyph,
  output logic [15:0] out_packed_value,
  output logic        out_last
);

  mrse_pkg::dig_t dig;

  mrse_split u_split (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .in_value            (in_value),
    .in_radix_mode       (in_radix_mode),
    .in_advance_position (in_advance_position),
    .busy                (busy),
    .dig_o               (dig)
  );

  mrse_glyph u_glyph (
    .clk                (clk),
    .rst_n              (rst_n),
    .dig_i              (dig),
    .out_valid          (out_valid),
    .out_digit_position (out_digit_position),
    .out_port1_bits     (out_port1_bits),
    .out_port2_bits     (out_port2_bits),
    .out_on_time        (out_on_time),
    .out_glyph_index    (out_glyph_index),
    .out_bad_glyph      (out_bad_glyph),
    .out_packed_value   (out_packed_value),
    .out_last           (out_last)
  );

endmodule
